FILE: src/ta_pkg.sv
package ta_pkg;

  localparam int Axes     = 6;
  localparam int MaxLanes = 8;
  localparam int KindW    = 2;
  localparam int ThrW     = 3;
  localparam int AxisW    = 3;
  localparam int CoefW    = 18;
  localparam int LimW     = 32;
  localparam int RcW      = 24;
  localparam int WordW    = 32;
  localparam int ActW     = 4;
  localparam int ProdW    = CoefW + WordW;   // one coefficient times one wrench term
  localparam int AccW     = ProdW + 2;       // six products, magnitude below 2^51
  localparam int MagW     = 38;              // rounded Q16.16 thrust magnitude
  localparam int FracW    = 16;
  localparam int DivW     = MagW + FracW;    // shared divider width
  localparam int RootW    = DivW / 2;
  localparam int SpeedW   = 32;

  localparam logic [ActW-1:0]   ActReset = 4'd8;
  localparam logic [DivW-1:0]   OneQ16   = 54'd65536;
  localparam logic [SpeedW-1:0] SpeedMax = 32'h7FFF_FFFF;
  localparam logic [SpeedW-1:0] SpeedMin = 32'h8000_0000;

  typedef enum logic [KindW-1:0] {
    KIND_COEF   = 2'd0,
    KIND_LIMIT  = 2'd1,
    KIND_WRENCH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef logic [Axes-1:0][WordW-1:0] wrench_t;

  typedef struct packed {
    logic                    ld_coef;
    logic                    ld_limit;
    logic [ThrW-1:0]         thruster;
    logic [AxisW-1:0]        axis;
    logic signed [CoefW-1:0] coef;
    logic [LimW-1:0]         limit;
    logic [RcW-1:0]          rotor;
    logic                    start_a;
    logic                    start_b;
    logic                    kill;
    logic [DivW-1:0]         scale;
    wrench_t                 wrench;
  } lane_cmd_t;

  typedef struct packed {
    logic              done_a;
    logic              done_b;
    logic              mag_nz;
    logic              lim_zero;
    logic [DivW-1:0]   ratio;
    logic [SpeedW-1:0] speed;
  } lane_stat_t;

endpackage

FILE: src/ta_in_if.sv
interface ta_in_if;
  import ta_pkg::*;
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [ThrW-1:0]     thruster;
  logic [AxisW-1:0]    axis;
  logic signed [CoefW-1:0] coefficient;
  logic [LimW-1:0]     thrust_limit;
  logic [RcW-1:0]      rotor_constant;
  logic signed [WordW-1:0] force_x;
  logic signed [WordW-1:0] force_y;
  logic signed [WordW-1:0] force_z;
  logic signed [WordW-1:0] torque_x;
  logic signed [WordW-1:0] torque_y;
  logic signed [WordW-1:0] torque_z;

  modport source (output valid, kind, thruster, axis, coefficient, thrust_limit,
                  rotor_constant, force_x, force_y, force_z, torque_x, torque_y,
                  torque_z, input ready);
  modport sink (input valid, kind, thruster, axis, coefficient, thrust_limit,
                rotor_constant, force_x, force_y, force_z, torque_x, torque_y,
                torque_z, output ready);
endinterface

FILE: src/ta_out_if.sv
interface ta_out_if;
  import ta_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ThrW-1:0]          thruster_index;
  logic signed [SpeedW-1:0] speed;
  logic                     scaled;
  logic                     last;

  modport source (output valid, thruster_index, speed, scaled, last, input ready);
  modport sink (input valid, thruster_index, speed, scaled, last, output ready);
endinterface

FILE: src/ta_cfg_if.sv
interface ta_cfg_if;
  import ta_pkg::*;
  logic            valid;
  logic            ready;
  logic [ActW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: src/ta_div.sv
// Restoring divider, one quotient bit a cycle.
module ta_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ta_pkg::DivW-1:0] dividend_i,
  input  logic [ta_pkg::DivW-1:0] divisor_i,
  output logic [ta_pkg::DivW-1:0] quotient_o,
  output logic                   done_o
);
  import ta_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] quo_q, div_q, rem_q;
  logic [DivW:0]   shifted, diff;
  logic            take;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign take    = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
        quo_q  <= dividend_i;
        div_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= take ? diff[DivW-1:0] : shifted[DivW-1:0];
        quo_q <= {quo_q[DivW-2:0], take};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;
endmodule

FILE: src/ta_lane.sv
// One thruster: coefficient store, MAC, ratio, scaled thrust, root and speed.
module ta_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ta_pkg::lane_cmd_t  cmd_i,
  output ta_pkg::lane_stat_t stat_o
);
  import ta_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE, L_MAC, L_ROUND, L_RSTART, L_RWAIT, L_TSTART, L_TWAIT, L_SQRT,
    L_VSTART, L_VWAIT
  } lstate_e;

  lstate_e                 state_q;
  logic [4:0]              cnt_q;
  logic signed [CoefW-1:0] coef_q [Axes];
  logic [LimW-1:0]         lim_q;
  logic [RcW-1:0]          rc_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic                    neg_q, tnz_q, done_a_q, done_b_q;
  logic [MagW-1:0]         mag_q;
  logic [DivW-1:0]         ratio_q, rad_q;
  logic [RootW:0]          rem_q;
  logic [RootW-1:0]        root_q;
  logic [SpeedW-1:0]       speed_q;

  logic [AxisW-1:0]        idx;
  logic signed [CoefW-1:0] coef_sel;
  logic signed [WordW-1:0] w_sel;
  logic signed [ProdW-1:0] prod;
  logic [AccW-1:0]         abs_acc, rnd;
  logic [RootW+2:0]        sq_sh, sq_trial;
  logic                    div_start, div_done;
  logic [DivW-1:0]         div_a, div_b, div_res, v;
  logic [SpeedW-1:0]       speed_d;

  assign idx      = (cnt_q < 5'(Axes)) ? cnt_q[AxisW-1:0] : '0;
  assign coef_sel = coef_q[idx];
  assign w_sel    = $signed(cmd_i.wrench[idx]);
  assign prod     = coef_sel * w_sel;
  assign abs_acc  = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  assign rnd      = abs_acc + AccW'(1 << 13);

  assign sq_sh    = {rem_q, rad_q[DivW-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};

  always_comb begin
    div_start = (state_q == L_RSTART) || (state_q == L_TSTART) ||
                (state_q == L_VSTART);
    case (state_q)
      L_RSTART: begin
        div_a = {mag_q, FracW'(0)} + DivW'(lim_q) - DivW'(1);
        div_b = DivW'(lim_q);
      end
      L_TSTART: begin
        div_a = {mag_q, FracW'(0)};
        div_b = cmd_i.scale;
      end
      default: begin
        div_a = DivW'({root_q, FracW'(0)});
        div_b = DivW'(rc_q);
      end
    endcase
  end

  ta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quotient_o (div_res),
    .done_o     (div_done)
  );

  // zero rotor constant saturates
  assign v = (rc_q == '0) ? '1 : div_res;

  always_comb begin
    if (!tnz_q) begin
      speed_d = '0;
    end else if (neg_q) begin
      speed_d = (v >= DivW'(SpeedMin)) ? SpeedMin : SpeedW'(-v[SpeedW-1:0]);
    end else begin
      speed_d = (v >= DivW'(SpeedMax)) ? SpeedMax : v[SpeedW-1:0];
    end
  end

  // tables, undefined until written
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_coef && cmd_i.thruster == ThrW'(LANE_IDX) &&
        cmd_i.axis < AxisW'(Axes)) begin
      coef_q[cmd_i.axis] <= cmd_i.coef;
    end
    if (cmd_i.ld_limit && cmd_i.thruster == ThrW'(LANE_IDX)) begin
      lim_q <= cmd_i.limit;
      rc_q  <= cmd_i.rotor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= L_IDLE;
      cnt_q    <= '0;
      done_a_q <= 1'b0;
      done_b_q <= 1'b0;
    end else begin
      done_a_q <= 1'b0;
      done_b_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (cmd_i.start_a) begin
            cnt_q   <= '0;
            acc_q   <= '0;
            state_q <= L_MAC;
          end else if (cmd_i.start_b) begin
            state_q <= L_TSTART;
          end
        end
        L_MAC: begin
          if (cnt_q < 5'(Axes)) prod_q <= prod;
          if (cnt_q != '0) begin
            acc_q <= acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
          end
          if (cnt_q == 5'(Axes)) state_q <= L_ROUND;
          else cnt_q <= cnt_q + 1'b1;
        end
        L_ROUND: begin
          neg_q   <= acc_q[AccW-1];
          mag_q   <= rnd[14 +: MagW];
          state_q <= L_RSTART;
        end
        L_RSTART: state_q <= L_RWAIT;
        L_RWAIT: begin
          if (div_done) begin
            ratio_q  <= div_res;
            done_a_q <= 1'b1;
            state_q  <= L_IDLE;
          end
        end
        L_TSTART: state_q <= L_TWAIT;
        L_TWAIT: begin
          if (div_done) begin
            tnz_q   <= !cmd_i.kill && (div_res != '0);
            rad_q   <= cmd_i.kill ? '0 : {div_res[MagW-1:0], FracW'(0)};
            root_q  <= '0;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= L_SQRT;
          end
        end
        L_SQRT: begin
          if (sq_sh >= sq_trial) begin
            rem_q  <= (RootW+1)'(sq_sh - sq_trial);
            root_q <= {root_q[RootW-2:0], 1'b1};
          end else begin
            rem_q  <= sq_sh[RootW:0];
            root_q <= {root_q[RootW-2:0], 1'b0};
          end
          rad_q <= {rad_q[DivW-3:0], 2'b00};
          if (cnt_q == 5'(RootW - 1)) state_q <= L_VSTART;
          else cnt_q <= cnt_q + 1'b1;
        end
        L_VSTART: state_q <= L_VWAIT;
        L_VWAIT: begin
          if (div_done) begin
            speed_q  <= speed_d;
            done_b_q <= 1'b1;
            state_q  <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign stat_o.done_a   = done_a_q;
  assign stat_o.done_b   = done_b_q;
  assign stat_o.mag_nz   = (mag_q != '0);
  assign stat_o.lim_zero = (lim_q == '0);
  assign stat_o.ratio    = ratio_q;
  assign stat_o.speed    = speed_q;
endmodule

FILE: src/ta_merge.sv
// Walks the active lanes one a cycle: largest ratio and zero-limit kill.
module ta_merge #(
  parameter int LANES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [$clog2(LANES+1)-1:0]    n_i,
  input  ta_pkg::lane_stat_t            stat_i [LANES],
  output logic [ta_pkg::DivW-1:0]       scale_o,
  output logic                          kill_o,
  output logic                          done_o
);
  import ta_pkg::*;

  localparam int CntW = $clog2(LANES + 1);

  logic            busy_q, done_q, kill_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] scale_q;
  lane_stat_t      sel;

  always_comb begin
    sel = stat_i[0];
    for (int j = 0; j < LANES; j++) begin
      if (cnt_q == CntW'(j)) sel = stat_i[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      kill_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        cnt_q   <= '0;
        kill_q  <= 1'b0;
        scale_q <= OneQ16;
      end else if (busy_q) begin
        if (sel.mag_nz) begin
          if (sel.lim_zero) kill_q <= 1'b1;
          else if (sel.ratio > scale_q) scale_q <= sel.ratio;
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == n_i - 1'b1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign scale_o = scale_q;
  assign kill_o  = kill_q;
  assign done_o  = done_q;
endmodule

FILE: src/thruster_allocation_top.sv
// A wrench item passes each lane's MAC and ratio division, the lane-by-lane
// merge, then each lane's scaled-thrust division, a 27-step root and the speed
// division (three passes of each lane's divider) before the first speed item.
// One item at a time: any item, wrench or load, is accepted only when the previous
// wrench has handed all its speeds to the output register. Speed items then leave
// at up to one a cycle while out_o.ready allows. Reset clears control state
// and sets active_thrusters to 8; the coefficient and limit tables are not cleared.
module thruster_allocation_top #(
  parameter int NUM_THRUSTERS = 8
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ta_in_if.sink  in_i,
  ta_cfg_if.sink cfg_i,
  ta_out_if.source out_o
);
  import ta_pkg::*;

  // lanes beyond eight are never addressable by a 3-bit thruster index
  localparam int Lanes = (NUM_THRUSTERS < MaxLanes) ? NUM_THRUSTERS : MaxLanes;
  localparam int CntW  = $clog2(Lanes + 1);

  typedef enum logic [2:0] {S_IDLE, S_PHA, S_MERGE, S_PHB, S_OUT} state_e;

  state_e            state_q;
  logic [ActW-1:0]   act_q;
  logic [CntW-1:0]   n_q, n_d, cnt_q;
  wrench_t           wrench_q;
  logic              out_valid_q, out_scaled_q, out_last_q;
  logic [ThrW-1:0]   out_idx_q;
  logic [SpeedW-1:0] out_speed_q;

  logic              in_acc, all_a, all_b, out_load;
  logic              merge_start, merge_done, kill;
  logic [DivW-1:0]   scale;
  lane_cmd_t         cmd;
  lane_stat_t        stat [Lanes];
  logic [SpeedW-1:0] speed_sel;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;

  // active count clamped to 1..Lanes
  always_comb begin
    if (act_q == '0) n_d = CntW'(1);
    else if (act_q > ActW'(Lanes)) n_d = CntW'(Lanes);
    else n_d = CntW'(act_q);
  end

  always_comb begin
    cmd.ld_coef  = in_acc && (kind_e'(in_i.kind) == KIND_COEF);
    cmd.ld_limit = in_acc && (kind_e'(in_i.kind) == KIND_LIMIT);
    cmd.start_a  = in_acc && (kind_e'(in_i.kind) == KIND_WRENCH);
    cmd.thruster = in_i.thruster;
    cmd.axis     = in_i.axis;
    cmd.coef     = in_i.coefficient;
    cmd.limit    = in_i.thrust_limit;
    cmd.rotor    = in_i.rotor_constant;
    cmd.start_b  = merge_done;
    cmd.kill     = kill;
    cmd.scale    = scale;
    cmd.wrench   = wrench_q;
  end

  // one lane per thruster, all on the same schedule
  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    ta_lane #(.LANE_IDX(g)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .stat_o (stat[g])
    );
  end

  always_comb begin
    all_a     = 1'b1;
    all_b     = 1'b1;
    speed_sel = stat[0].speed;
    for (int j = 0; j < Lanes; j++) begin
      all_a = all_a & stat[j].done_a;
      all_b = all_b & stat[j].done_b;
      if (cnt_q == CntW'(j)) speed_sel = stat[j].speed;
    end
  end

  assign merge_start = (state_q == S_PHA) && all_a;

  ta_merge #(.LANES(Lanes)) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (merge_start),
    .n_i     (n_q),
    .stat_i  (stat),
    .scale_o (scale),
    .kill_o  (kill),
    .done_o  (merge_done)
  );

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ActReset;
      n_q         <= CntW'(1);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) act_q <= cfg_i.data;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd.start_a) begin
            wrench_q <= {in_i.torque_z, in_i.torque_y, in_i.torque_x,
                         in_i.force_z, in_i.force_y, in_i.force_x};
            n_q      <= n_d;
            state_q  <= S_PHA;
          end
        end
        S_PHA:   if (all_a) state_q <= S_MERGE;
        S_MERGE: if (merge_done) state_q <= S_PHB;
        S_PHB: begin
          if (all_b) begin
            cnt_q   <= '0;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_idx_q    <= ThrW'(cnt_q);
            out_speed_q  <= speed_sel;
            out_scaled_q <= kill || (scale > OneQ16);
            out_last_q   <= (cnt_q == n_q - 1'b1);
            cnt_q        <= cnt_q + 1'b1;
            if (cnt_q == n_q - 1'b1) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.thruster_index = out_idx_q;
  assign out_o.speed          = out_speed_q;
  assign out_o.scaled         = out_scaled_q;
  assign out_o.last           = out_last_q;

  // lanes share one schedule, so their phase ends coincide
  a_lanes_a_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat[0].done_a |-> all_a) else $error("lanes out of step in phase A");
  a_merge_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_done |-> state_q == S_MERGE) else $error("merge finished out of turn");
  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> cnt_q < n_q) else $error("speed count overrun");
  a_wrench_starts_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_a |=> state_q == S_PHA) else $error("wrench did not start lanes");
endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ta_pkg::*;

  localparam int Lanes      = 8;
  localparam int IdlePct    = 36;
  localparam int StallLimit = 20000;
  // idle margin that drain() waits after the last owed speed; generous
  localparam int DrainCycles = 400;

  typedef struct {
    kind_e                   kind;
    logic [ThrW-1:0]         thr;
    logic [AxisW-1:0]        axis;
    logic signed [CoefW-1:0] coef;
    logic [LimW-1:0]         lim;
    logic [RcW-1:0]          rc;
    logic signed [WordW-1:0] w [Axes];
  } alloc_item_t;

  typedef struct {
    logic [ThrW-1:0]   idx;
    logic [SpeedW-1:0] speed;
    logic              scaled;
    logic              last;
  } speed_item_t;

  // Allocation predictor plus the queue of speeds still owed by the block.
  class speed_board;
    logic signed [CoefW-1:0] coef_tab [Lanes*Axes];
    logic [LimW-1:0]         lim_tab  [Lanes];
    logic [RcW-1:0]          rc_tab   [Lanes];
    logic [ActW-1:0]         active;
    speed_item_t             owed [$];
    int errors, wrenches, kills, scaled_cnt, speeds;

    function new();
      active = ActReset;
    endfunction

    static function longint unsigned root64(longint unsigned v);
      longint unsigned r, c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function void note_item(alloc_item_t it);
      longint          acc;
      longint unsigned mag [Lanes];
      bit              neg [Lanes];
      longint unsigned scale, ratio, t, s, v;
      bit              kill;
      int              n;
      speed_item_t     res;
      case (it.kind)
        KIND_COEF: begin
          if (it.axis < Axes) coef_tab[it.thr*Axes + it.axis] = it.coef;
        end
        KIND_LIMIT: begin
          lim_tab[it.thr] = it.lim;
          rc_tab[it.thr]  = it.rc;
        end
        KIND_WRENCH: begin
          wrenches++;
          n = (active == 0) ? 1 : (active > Lanes ? Lanes : int'(active));
          scale = 65536;
          kill  = 0;
          for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int a = 0; a < Axes; a++)
              acc += longint'(coef_tab[i*Axes + a]) * longint'(it.w[a]);
            neg[i] = acc < 0;
            mag[i] = neg[i] ? longint'(-acc) : acc;
            mag[i] = (mag[i] + (64'd1 << 13)) >> 14;
            if (mag[i] != 0) begin
              if (lim_tab[i] == 0) kill = 1;
              else begin
                ratio = ((mag[i] << 16) + lim_tab[i] - 1) / lim_tab[i];
                if (ratio > scale) scale = ratio;
              end
            end
          end
          if (kill) kills++;
          if (kill || scale > 65536) scaled_cnt++;
          for (int i = 0; i < n; i++) begin
            t = kill ? 0 : (mag[i] << 16) / scale;
            res.speed = '0;
            if (t != 0) begin
              s = root64(t << 16);
              v = (rc_tab[i] == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : (s << 16) / rc_tab[i];
              if (neg[i]) res.speed = (v >= 64'h8000_0000) ? SpeedMin : -v[31:0];
              else        res.speed = (v >= 64'h7FFF_FFFF) ? SpeedMax : v[31:0];
            end
            res.idx    = i[ThrW-1:0];
            res.scaled = kill || scale > 65536;
            res.last   = (i == n - 1);
            owed = {owed, res};
          end
        end
        default: ;  // unused kind: ignored
      endcase
    endfunction

    function void check_result(speed_item_t got);
      speed_item_t exp;
      speeds++;
      if (owed.size() == 0) begin
        $error("speed item with nothing expected: index %0d speed %0d", got.idx, got.speed);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.idx !== exp.idx) begin
        $error("thruster_index: expected %0d, got %0d", exp.idx, got.idx);
        errors++;
      end
      if (got.speed !== exp.speed) begin
        $error("speed: expected %0d, got %0d", $signed(exp.speed), $signed(got.speed));
        errors++;
      end
      if (got.scaled !== exp.scaled) begin
        $error("scaled: expected %0b, got %0b", exp.scaled, got.scaled);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0b, got %0b", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   no_idle = 0;   // set for stretches of back-to-back traffic
  int   quiet = 0;     // cycles without any accepted item
  speed_board board = new();

  ta_in_if  in_bus ();
  ta_cfg_if cfg_bus ();
  ta_out_if out_bus ();

  thruster_allocation_top #(.NUM_THRUSTERS(Lanes)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (out_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit idle_now();
    return !no_idle && $urandom_range(99) < IdlePct;
  endfunction

  // Receiver: random back-pressure, checked at the rising edge.
  always @(negedge clk_i) out_bus.ready <= rst_ni && !idle_now();

  always @(posedge clk_i) begin
    speed_item_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.idx    = out_bus.thruster_index;
      got.speed  = out_bus.speed;
      got.scaled = out_bus.scaled;
      got.last   = out_bus.last;
      board.check_result(got);
    end
  end

  // Watchdog: nothing accepted anywhere for too long means the block hung.
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
        (out_bus.valid && out_bus.ready) || !rst_ni)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(alloc_item_t it);
    @(negedge clk_i);
    while (idle_now()) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid          = 1'b1;
    in_bus.kind           = it.kind;
    in_bus.thruster       = it.thr;
    in_bus.axis           = it.axis;
    in_bus.coefficient    = it.coef;
    in_bus.thrust_limit   = it.lim;
    in_bus.rotor_constant = it.rc;
    in_bus.force_x        = it.w[0];
    in_bus.force_y        = it.w[1];
    in_bus.force_z        = it.w[2];
    in_bus.torque_x       = it.w[3];
    in_bus.torque_y       = it.w[4];
    in_bus.torque_z       = it.w[5];
    do @(posedge clk_i); while (!in_bus.ready);
    board.note_item(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (board.owed.size() != 0) @(posedge clk_i);
    // a trailing load item may still be in flight
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register write only once the block has gone idle.
  task automatic write_active(logic [ActW-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.data  = value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    board.active = value;
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic alloc_item_t blank(kind_e k);
    alloc_item_t it;
    it.kind = k;
    it.thr  = '0;
    it.axis = '0;
    it.coef = '0;
    it.lim  = '0;
    it.rc   = '0;
    foreach (it.w[a]) it.w[a] = '0;
    return it;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(2097151)) - 1048576);
      2:       return 32'($signed($urandom_range(131071)) - 65536);
      default: return '0;
    endcase
  endfunction

  function automatic alloc_item_t rand_item();
    alloc_item_t it;
    int pick;
    pick    = $urandom_range(99);
    it      = blank(KIND_WRENCH);
    it.thr  = ThrW'($urandom_range(7));
    it.axis = AxisW'($urandom_range(7));   // axes 6 and 7 must be ignored
    it.coef = CoefW'($urandom());
    it.lim  = ($urandom_range(19) == 0) ? 0 :
              ($urandom_range(1) ? $urandom() : $urandom_range(1 << 22));
    it.rc   = ($urandom_range(19) == 0) ? '0 : RcW'($urandom());
    foreach (it.w[a]) it.w[a] = rand_word();
    if (pick < 6)       it.kind = KIND_NONE;
    else if (pick < 18) it.kind = KIND_COEF;
    else if (pick < 26) it.kind = KIND_LIMIT;
    return it;
  endfunction

  initial begin
    alloc_item_t it;
    logic [ActW-1:0] settings [6];
    settings              = '{4'd1, 4'd0, 4'd15, 4'd5, 4'd3, 4'd8};
    in_bus.valid          = 1'b0;
    in_bus.kind           = KIND_NONE;
    in_bus.thruster       = '0;
    in_bus.axis           = '0;
    in_bus.coefficient    = '0;
    in_bus.thrust_limit   = '0;
    in_bus.rotor_constant = '0;
    in_bus.force_x        = '0;
    in_bus.force_y        = '0;
    in_bus.force_z        = '0;
    in_bus.torque_x       = '0;
    in_bus.torque_y       = '0;
    in_bus.torque_z       = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.data          = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_active(4'd8);

    // Fill every table entry before any wrench reads one.
    for (int t = 0; t < Lanes; t++) begin
      for (int a = 0; a < Axes; a++) begin
        it = blank(KIND_COEF);
        it.thr = ThrW'(t); it.axis = AxisW'(a);
        it.coef = CoefW'(int'($urandom_range(8191)) - 4096);
        send_item(it);
      end
      it = blank(KIND_LIMIT);
      it.thr = ThrW'(t); it.lim = 32'h0100_0000; it.rc = 24'h01_0000;
      send_item(it);
    end

    // Directed: coefficient and limit extremes, zero wrench, full-scale wrench,
    // zero limit with demand, zero rotor constant, ignored loads.
    it = blank(KIND_WRENCH);
    send_item(it);
    it = blank(KIND_COEF); it.coef = 18'sh1FFFF; send_item(it);
    it = blank(KIND_COEF); it.thr = 3'd1; it.coef = -18'sh20000; send_item(it);
    it = blank(KIND_COEF); it.thr = 3'd7; it.axis = 3'd5; it.coef = -18'sd1; send_item(it);
    it = blank(KIND_COEF); it.axis = 3'd6; it.coef = 18'sh1FFFF; send_item(it);
    it = blank(KIND_COEF); it.axis = 3'd7; it.coef = -18'sh20000; send_item(it);
    it = blank(KIND_NONE); it.thr = 3'd7; it.axis = 3'd7; it.coef = -18'sd1;
    it.lim = '1; it.rc = '1; foreach (it.w[a]) it.w[a] = '1; send_item(it);
    it = blank(KIND_LIMIT); it.lim = 32'hFFFF_FFFF; it.rc = 24'hFF_FFFF; send_item(it);
    it = blank(KIND_WRENCH); foreach (it.w[a]) it.w[a] = 32'sh7FFF_FFFF; send_item(it);
    it = blank(KIND_WRENCH); foreach (it.w[a]) it.w[a] = -32'sh8000_0000; send_item(it);
    it = blank(KIND_WRENCH); it.w[0] = 32'sh0001_0000; it.w[5] = -32'sh0000_8000;
    send_item(it);
    it = blank(KIND_LIMIT); it.thr = 3'd2; it.lim = '0; it.rc = 24'h00_1000; send_item(it);
    it = blank(KIND_WRENCH); it.w[1] = 32'sh0040_0000; send_item(it);
    it = blank(KIND_LIMIT); it.thr = 3'd2; it.lim = 32'h0000_0001; it.rc = '0; send_item(it);
    it = blank(KIND_WRENCH); it.w[2] = -32'sh0040_0000; send_item(it);
    it = blank(KIND_WRENCH); it.w[3] = 32'sh0000_0001; send_item(it);
    it = blank(KIND_LIMIT); it.thr = 3'd2; it.lim = 32'h0100_0000; it.rc = 24'h01_0000;
    send_item(it);

    // Random phases across active-thruster settings, extremes included.
    foreach (settings[p]) begin
      write_active(settings[p]);
      no_idle = (p == 2);
      for (int k = 0; k < 60; k++) send_item(rand_item());
      no_idle = 0;
    end

    drain();
    $display("Covered %0d wrench items over active counts 0..15: %0d scaled, %0d zero-limit",
             board.wrenches, board.scaled_cnt, board.kills);
    $display("%0d speed items checked, %0d mismatches", board.speeds, board.errors);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: thruster_allocation_top.f
src/ta_pkg.sv
src/ta_in_if.sv
src/ta_out_if.sv
src/ta_cfg_if.sv
src/ta_div.sv
src/ta_lane.sv
src/ta_merge.sv
src/thruster_allocation_top.sv
tb/testbench.sv
